FILE: design/rsp_pkg.sv
// rsp_pkg: shared types, constants and helpers of the road segment projector
// no dependencies; imported by rsp_div and road_segment_projector

package rsp_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH   = 3'd0,
    REG_SCREEN_HEIGHT  = 3'd1,
    REG_ROAD_WIDTH     = 3'd2,
    REG_SEGMENT_LENGTH = 3'd3,
    REG_CAMERA_DEPTH   = 3'd4
  } cfg_reg_t;

  // register reset values
  localparam logic [12:0] SCREEN_WIDTH_RST   = 13'd1024;
  localparam logic [12:0] SCREEN_HEIGHT_RST  = 13'd768;
  localparam logic [15:0] ROAD_WIDTH_RST     = 16'd2000;
  localparam logic [11:0] SEGMENT_LENGTH_RST = 12'd200;
  localparam logic [15:0] CAMERA_DEPTH_RST   = 16'd215;
  localparam logic [15:0] CLIP_LINE_RST      = 16'd768;

  // pixel saturation limits
  localparam logic [15:0] PIX_MIN = 16'h8000;
  localparam logic [15:0] PIX_MAX = 16'h7FFF;
  localparam logic [14:0] HW_MAX  = 15'h7FFF;

  // offset and slope saturation limits
  localparam logic [31:0] OFS_MIN = 32'h8000_0000;
  localparam logic [31:0] OFS_MAX = 32'h7FFF_FFFF;
  localparam logic [23:0] SLP_MIN = 24'h80_0000;
  localparam logic [23:0] SLP_MAX = 24'h7F_FFFF;

  // shared divider: 17 quotient bits, the top one flags overflow
  localparam int unsigned DIVIDEND_W = 45;
  localparam int unsigned DIVISOR_W  = 28;
  localparam int unsigned QUO_W      = 17;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [QUO_W-2:0]   quo;
  } div_res_t;

  // (n / 3) mod 2 through a reciprocal, exact for 12-bit n
  function automatic logic stripe_of(input logic [11:0] n);
    logic [25:0] p;
    p = 26'(n) * 26'd2731;
    return p[13];
  endfunction

endpackage

FILE: design/road_segment_projector.sv
// road_segment_projector: pseudo-3d road segment projection, one segment per transfer
// depends on rsp_pkg and rsp_div (shared restoring divider)
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------------
//   cfg      | cfg_valid/ready    | cfg_index, cfg_data (register write)
//   in       | in_valid/in_stall  | first, segment_number, cam_x, cam_y, seg_height,
//            |                    | seg_curve
//   out      | out_valid/out_stall| screen_x, screen_y, half_width, prev_*,
//            |                    | clip_limit, visible, stripe
//
// a segment holds the block from its transfer to the earliest next input transfer;
// three 17-step divisions through the one shared divider follow the products and
// are skipped when its depth is zero; the products go through one registered
// 30x19 multiplier, one per cycle.
// synchronous reset loads the register defaults and the frame state; in_stall is
// high during reset and while a segment is in work.
// a finished result waits in the output register; a new segment is taken meanwhile,
// and the sequencer only holds in its last step while that register is full and stalled.

module road_segment_projector (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsp_pkg::CFG_DATA_W-1:0]    cfg_data,
  // segment input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              first,
  input  logic [11:0]                       segment_number,
  input  logic signed [20:0]                cam_x,
  input  logic signed [16:0]                cam_y,
  input  logic signed [15:0]                seg_height,
  input  logic signed [9:0]                 seg_curve,
  // projection result
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [15:0]                screen_x,
  output logic signed [15:0]                screen_y,
  output logic [14:0]                       half_width,
  output logic signed [15:0]                prev_x,
  output logic signed [15:0]                prev_y,
  output logic [14:0]                       prev_half_width,
  output logic signed [15:0]                clip_limit,
  output logic                              visible,
  output logic                              stripe
);
  import rsp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_DEPTH,
    ST_MUL_CW,
    ST_MUL_CH,
    ST_MUL_BX,
    ST_MUL_BY,
    ST_MUL_HW,
    ST_MUL_XLO,
    ST_MUL_XHI,
    ST_MUL_Y,
    ST_SUM,
    ST_PREP,
    ST_DX,
    ST_DX_WAIT,
    ST_DY,
    ST_DY_WAIT,
    ST_DH,
    ST_DH_WAIT,
    ST_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic [15:0] road_width;
  logic [11:0] segment_length;
  logic [15:0] camera_depth;

  // frame state
  logic [31:0] curve_offset;
  logic [23:0] curve_slope;
  logic [15:0] clip_line;
  logic [15:0] depth_count;
  logic [15:0] last_x;
  logic [15:0] last_y;
  logic [14:0] last_hw;

  // segment in work
  logic [20:0] item_cam_x;
  logic [16:0] item_cam_y;
  logic [15:0] item_height;
  logic [9:0]  item_curve;
  logic        item_stripe;

  // working registers of the sequence
  logic [32:0] dx;          // cam_x*256 - offset, signed
  logic [27:0] depth;
  logic [28:0] cam_w;       // c*W
  logic [28:0] cam_h;       // c*H
  logic [44:0] base_x;      // depth*(W+65537)
  logic [44:0] base_y;      // depth*(H+65537)
  logic [44:0] hw_prod;     // c*W*road_width
  logic [44:0] part_lo;     // c*W*dx[15:0]
  logic [45:0] part_hi;     // c*W*dx[32:16], signed
  logic [46:0] y_prod;      // c*H*dy, signed
  logic [46:0] x_diff;      // signed
  logic [63:0] num_x;       // signed, offset by half the output range
  logic [63:0] num_y;       // signed, offset by half the output range
  logic [45:0] num_hw;
  logic [15:0] res_x;
  logic [15:0] res_y;
  logic [14:0] res_hw;

  // shared multiplier
  logic signed [29:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [48:0] prod;

  // combinational helpers
  logic        accept;
  logic        out_free;
  logic [17:0] dy;
  logic [16:0] wide_w;
  logic [16:0] wide_h;
  logic [53:0] y_diff;
  logic [32:0] ofs_sum;
  logic [24:0] slp_sum;
  logic [31:0] curve_offset_next;
  logic [23:0] curve_slope_next;
  logic        visible_next;

  // divider hookup
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  div_res_t              div_res;

  assign cfg_ready = !rst;
  assign in_stall  = rst || (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // height difference of the road line to the camera, signed
  assign dy     = {{2{item_height[15]}}, item_height} - {item_cam_y[16], item_cam_y};
  assign wide_w = {4'b0, screen_width} + 17'd65537;
  assign wide_h = {4'b0, screen_height} + 17'd65537;
  assign y_diff = {1'b0, base_y, 8'b0} - {{7{y_prod[46]}}, y_prod};

  // saturating frame updates
  assign ofs_sum = {curve_offset[31], curve_offset} + {{9{curve_slope[23]}}, curve_slope};
  assign slp_sum = {curve_slope[23], curve_slope} + {{15{item_curve[9]}}, item_curve};
  assign curve_offset_next = (ofs_sum[32] != ofs_sum[31]) ?
                             (ofs_sum[32] ? OFS_MIN : OFS_MAX) : ofs_sum[31:0];
  assign curve_slope_next  = (slp_sum[24] != slp_sum[23]) ?
                             (slp_sum[24] ? SLP_MIN : SLP_MAX) : slp_sum[23:0];

  // drawn when in front of the camera and above the current clip line
  assign visible_next = (depth != '0) && ($signed(res_y) < $signed(clip_line));

  // operand selection for the one multiplier, one product per state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_DEPTH: begin
        mul_a = {14'b0, depth_count};
        mul_b = {7'b0, segment_length};
      end
      ST_MUL_CW: begin
        mul_a = {14'b0, camera_depth};
        mul_b = {6'b0, screen_width};
      end
      ST_MUL_CH: begin
        mul_a = {14'b0, camera_depth};
        mul_b = {6'b0, screen_height};
      end
      ST_MUL_BX: begin
        mul_a = {2'b0, depth};
        mul_b = {2'b0, wide_w};
      end
      ST_MUL_BY: begin
        mul_a = {2'b0, depth};
        mul_b = {2'b0, wide_h};
      end
      ST_MUL_HW: begin
        mul_a = {1'b0, cam_w};
        mul_b = {3'b0, road_width};
      end
      ST_MUL_XLO: begin
        mul_a = {1'b0, cam_w};
        mul_b = {3'b0, dx[15:0]};
      end
      ST_MUL_XHI: begin
        mul_a = {1'b0, cam_w};
        mul_b = {{2{dx[32]}}, dx[32:16]};
      end
      ST_MUL_Y: begin
        mul_a = {1'b0, cam_h};
        mul_b = {dy[17], dy};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // divider start and dividend: floor(n / 2^k) first, then divide by the depth
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {8'b0, num_hw[45:9]};
    case (state)
      ST_DX: begin
        div_start    = 1'b1;
        div_dividend = num_x[61:17];
      end
      ST_DY: begin
        div_start    = 1'b1;
        div_dividend = num_y[61:17];
      end
      ST_DH: begin
        div_start    = 1'b1;
        div_dividend = {8'b0, num_hw[45:9]};
      end
      default: begin
        div_start    = 1'b0;
        div_dividend = {8'b0, num_hw[45:9]};
      end
    endcase
  end

  rsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (depth),
    .res      (div_res)
  );

  // undo the half-range offset of the axis quotient and saturate
  function automatic logic [15:0] axis_sat(input logic neg, input div_res_t r);
    logic [15:0] v;
    if (neg) begin
      v = PIX_MIN;
    end else if (r.ovf) begin
      v = PIX_MAX;
    end else begin
      v = {~r.quo[15], r.quo[14:0]};
    end
    return v;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width   <= SCREEN_WIDTH_RST;
      screen_height  <= SCREEN_HEIGHT_RST;
      road_width     <= ROAD_WIDTH_RST;
      segment_length <= SEGMENT_LENGTH_RST;
      camera_depth   <= CAMERA_DEPTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:   screen_width   <= cfg_data[12:0];
        REG_SCREEN_HEIGHT:  screen_height  <= cfg_data[12:0];
        REG_ROAD_WIDTH:     road_width     <= cfg_data;
        REG_SEGMENT_LENGTH: segment_length <= cfg_data[11:0];
        REG_CAMERA_DEPTH:   camera_depth   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer, frame state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      curve_offset <= '0;
      curve_slope  <= '0;
      clip_line    <= CLIP_LINE_RST;
      depth_count  <= '0;
      last_x       <= '0;
      last_y       <= '0;
      last_hw      <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            item_cam_x  <= cam_x;
            item_cam_y  <= cam_y;
            item_height <= seg_height;
            item_curve  <= seg_curve;
            item_stripe <= stripe_of(segment_number);
            // nearest segment: start a new frame
            if (first) begin
              curve_offset <= '0;
              curve_slope  <= '0;
              clip_line    <= {3'b0, screen_height};
              depth_count  <= '0;
              last_x       <= '0;
              last_y       <= '0;
              last_hw      <= '0;
            end
            state <= ST_MUL_DEPTH;
          end
        end
        ST_MUL_DEPTH: begin
          dx    <= {{4{item_cam_x[20]}}, item_cam_x, 8'b0} - {curve_offset[31], curve_offset};
          state <= ST_MUL_CW;
        end
        ST_MUL_CW: begin
          depth <= prod[27:0];
          state <= ST_MUL_CH;
        end
        ST_MUL_CH: begin
          cam_w <= prod[28:0];
          state <= ST_MUL_BX;
        end
        ST_MUL_BX: begin
          cam_h <= prod[28:0];
          state <= ST_MUL_BY;
        end
        ST_MUL_BY: begin
          base_x <= prod[44:0];
          state  <= ST_MUL_HW;
        end
        ST_MUL_HW: begin
          base_y <= prod[44:0];
          state  <= ST_MUL_XLO;
        end
        ST_MUL_XLO: begin
          hw_prod <= prod[44:0];
          state   <= ST_MUL_XHI;
        end
        ST_MUL_XHI: begin
          part_lo <= prod[44:0];
          state   <= ST_MUL_Y;
        end
        ST_MUL_Y: begin
          part_hi <= prod[45:0];
          state   <= ST_SUM;
        end
        ST_SUM: begin
          y_prod <= prod[46:0];
          x_diff <= {2'b0, base_x} - {part_hi[45], part_hi};
          num_hw <= {1'b0, hw_prod} + {10'b0, depth, 8'b0};
          state  <= ST_PREP;
        end
        ST_PREP: begin
          num_x <= {x_diff[46], x_diff, 16'b0} - {19'b0, part_lo};
          num_y <= {{2{y_diff[53]}}, y_diff, 8'b0};
          // zero depth: nothing to project
          if (depth == '0) begin
            res_x  <= '0;
            res_y  <= '0;
            res_hw <= '0;
            state  <= ST_FIN;
          end else begin
            state <= ST_DX;
          end
        end
        ST_DX: begin
          state <= ST_DX_WAIT;
        end
        ST_DX_WAIT: begin
          if (div_res.done) begin
            res_x <= axis_sat(num_x[63], div_res);
            state <= ST_DY;
          end
        end
        ST_DY: begin
          state <= ST_DY_WAIT;
        end
        ST_DY_WAIT: begin
          if (div_res.done) begin
            res_y <= axis_sat(num_y[63], div_res);
            state <= ST_DH;
          end
        end
        ST_DH: begin
          state <= ST_DH_WAIT;
        end
        ST_DH_WAIT: begin
          if (div_res.done) begin
            res_hw <= (div_res.ovf || div_res.quo[15]) ? HW_MAX : div_res.quo[14:0];
            state  <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            screen_x        <= res_x;
            screen_y        <= res_y;
            half_width      <= res_hw;
            prev_x          <= last_x;
            prev_y          <= last_y;
            prev_half_width <= last_hw;
            clip_limit      <= clip_line;
            visible         <= visible_next;
            stripe          <= item_stripe;
            if (visible_next) begin
              clip_line <= res_y;
            end
            curve_offset <= curve_offset_next;
            curve_slope  <= curve_slope_next;
            if (depth_count != 16'hFFFF) begin
              depth_count <= depth_count + 16'd1;
            end
            last_x  <= res_x;
            last_y  <= res_y;
            last_hw <= res_hw;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // divider finishes only while the sequencer waits on it
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == ST_DX_WAIT || state == ST_DY_WAIT || state == ST_DH_WAIT))
    else $error("divider result with no waiting step");

  // a drawn segment lies strictly above the clip line it was tested against
  a_visible_above_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && visible |-> $signed(screen_y) < $signed(clip_limit))
    else $error("visible segment not above clip line");

  // a new result only leaves the final step of the sequence
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result raised outside the final step");

  // within a frame the clip line only moves up the screen
  a_clip_moves_up: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(in_valid && !in_stall && first) &&
    (clip_line != $past(clip_line)) |-> $signed(clip_line) < $signed($past(clip_line)))
    else $error("clip line moved down within a frame");
`endif

endmodule

FILE: design/rsp_div.sv
// rsp_div: restoring divider, one quotient bit per cycle, shared by all projections
// depends on rsp_pkg for widths and the result struct

module rsp_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rsp_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [rsp_pkg::DIVISOR_W-1:0]     divisor,
  output rsp_pkg::div_res_t                 res
);
  import rsp_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);
  localparam int unsigned DVS_W = DIVISOR_W + QUO_W - 1;

  logic [CNT_W-1:0]      count;
  logic                  done;
  logic [DIVIDEND_W-1:0] rem;
  logic [DVS_W-1:0]      dvs;
  logic [QUO_W-1:0]      quo;
  logic                  fits;

  assign fits = rem >= DIVIDEND_W'(dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_W'(QUO_W);
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dvs <= {divisor, {(QUO_W-1){1'b0}}};
      quo <= '0;
    end else if (count != '0) begin
      if (fits) begin
        rem <= rem - DIVIDEND_W'(dvs);
      end
      quo <= {quo[QUO_W-2:0], fits};
      dvs <= dvs >> 1;
    end
  end

  assign res.done = done;
  assign res.ovf  = quo[QUO_W-1];
  assign res.quo  = quo[QUO_W-2:0];

endmodule

FILE: tb/sv/road_segment_projector_tb.sv
// road_segment_projector_tb: self-checking bench for the pseudo-3d road segment projector
// depends on rsp_pkg and road_segment_projector; a queue-fed driver, a checking monitor
// and a bit-exact fixed-point projection predictor kept in step with every transfer

module road_segment_projector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsp_pkg::*;

  // one segment as it crosses the input channel
  typedef struct {
    logic               first;
    logic [11:0]        segment_number;
    logic signed [20:0] cam_x;
    logic signed [16:0] cam_y;
    logic signed [15:0] seg_height;
    logic signed [9:0]  seg_curve;
  } segment_t;

  // one projection as it crosses the output channel
  typedef struct {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [14:0]        half_width;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    logic [14:0]        prev_half_width;
    logic signed [15:0] clip_limit;
    logic               visible;
    logic               stripe;
  } projection_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // block ports, every input known from time zero
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  first = 1'b0;
  logic [11:0]           segment_number = '0;
  logic signed [20:0]    cam_x = '0;
  logic signed [16:0]    cam_y = '0;
  logic signed [15:0]    seg_height = '0;
  logic signed [9:0]     seg_curve = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [15:0]    screen_x;
  logic signed [15:0]    screen_y;
  logic [14:0]           half_width;
  logic signed [15:0]    prev_x;
  logic signed [15:0]    prev_y;
  logic [14:0]           prev_half_width;
  logic signed [15:0]    clip_limit;
  logic                  visible;
  logic                  stripe;

  road_segment_projector dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .first           (first),
    .segment_number  (segment_number),
    .cam_x           (cam_x),
    .cam_y           (cam_y),
    .seg_height      (seg_height),
    .seg_curve       (seg_curve),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .screen_x        (screen_x),
    .screen_y        (screen_y),
    .half_width      (half_width),
    .prev_x          (prev_x),
    .prev_y          (prev_y),
    .prev_half_width (prev_half_width),
    .clip_limit      (clip_limit),
    .visible         (visible),
    .stripe          (stripe)
  );

  // segments waiting to be driven, projections waiting to come out
  segment_t    segment_q[$];
  projection_t projection_q[$];

  // register copy, follows every configuration transfer
  longint scr_w   = longint'(SCREEN_WIDTH_RST);
  longint scr_h   = longint'(SCREEN_HEIGHT_RST);
  longint road_w  = longint'(ROAD_WIDTH_RST);
  longint seg_len = longint'(SEGMENT_LENGTH_RST);
  longint cam_dep = longint'(CAMERA_DEPTH_RST);

  // frame state copy, same reset as the block
  longint      curve_ofs  = 0;
  longint      curve_slp  = 0;
  longint      clip_ln    = longint'(CLIP_LINE_RST);
  int unsigned depth_cnt  = 0;
  longint      last_sx    = 0;
  longint      last_sy    = 0;
  longint      last_hw    = 0;

  // run statistics
  int error_count   = 0;
  int checked_count = 0;
  int visible_count = 0;
  int frame_count   = 0;
  int write_count   = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // floor(num/den + 1/2) for den > 0, i.e. round half toward plus infinity
  function automatic longint round_half_up(longint num, longint den);
    longint a, b, q;
    a = 2 * num + den;
    b = 2 * den;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // span/2 - c*delta*span/(131072*depth), delta carries 8 fraction bits
  function automatic longint project_axis(longint span, longint delta, longint c,
                                          longint depth);
    return clamp(round_half_up(65536 * depth * span - c * delta * span, 131072 * depth),
                 -32768, 32767);
  endfunction

  // advances the frame state by one segment and returns its projection
  function automatic projection_t project_segment(segment_t s);
    projection_t r;
    longint      depth, sx, sy, hw;
    logic        vis;
    sx  = 0;
    sy  = 0;
    hw  = 0;
    vis = 1'b0;
    if (s.first) begin
      curve_ofs = 0;
      curve_slp = 0;
      clip_ln   = scr_h;
      depth_cnt = 0;
      last_sx   = 0;
      last_sy   = 0;
      last_hw   = 0;
    end
    r.prev_x          = 16'(last_sx);
    r.prev_y          = 16'(last_sy);
    r.prev_half_width = 15'(last_hw);
    r.clip_limit      = 16'(clip_ln);
    depth = longint'(depth_cnt) * seg_len;
    // zero depth means the point sits at the eye: nothing projected, clip untouched
    if (depth > 0) begin
      sx = project_axis(scr_w, longint'(s.cam_x) * 256 - curve_ofs, cam_dep, depth);
      sy = project_axis(scr_h, (longint'(s.seg_height) - longint'(s.cam_y)) * 256,
                        cam_dep, depth);
      hw = clamp(round_half_up(cam_dep * road_w * scr_w, 512 * depth), 0, 32767);
      if (sy < clip_ln) begin
        vis     = 1'b1;
        clip_ln = sy;
      end
    end
    curve_ofs = clamp(curve_ofs + curve_slp, -64'sd2147483648, 64'sd2147483647);
    curve_slp = clamp(curve_slp + longint'(s.seg_curve), -64'sd8388608, 64'sd8388607);
    if (depth_cnt < 65535) depth_cnt++;
    last_sx = sx;
    last_sy = sy;
    last_hw = hw;
    r.screen_x   = 16'(sx);
    r.screen_y   = 16'(sy);
    r.half_width = 15'(hw);
    r.visible    = vis;
    r.stripe     = 1'(s.segment_number / 12'd3);
    return r;
  endfunction

  // idle draw shared by both sides: mostly a random wait, with runs of no idling
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: takes segments off the queue, one transfer at a time
  // ---------------------------------------------------------------------------
  segment_t drv_seg;
  int       drv_gap   = 0;
  int       drv_quiet = 0;
  logic     drv_busy;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      drv_busy = in_valid;
      // transfer at this edge: predict now, while the register copy is current
      if (in_valid && !in_stall) begin
        projection_q = {projection_q, project_segment(drv_seg)};
        if (drv_seg.first) frame_count++;
        drv_busy = 1'b0;
        drv_gap  = draw_wait(drv_quiet);
      end
      if (!drv_busy) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (segment_q.size() != 0) begin
          drv_seg = segment_q.pop_front();
          drv_busy = 1'b1;
          first          <= drv_seg.first;
          segment_number <= drv_seg.segment_number;
          cam_x          <= drv_seg.cam_x;
          cam_y          <= drv_seg.cam_y;
          seg_height     <= drv_seg.seg_height;
          seg_curve      <= drv_seg.seg_curve;
        end
      end
      // single assignment per edge, so back-to-back transfers keep valid high
      in_valid <= drv_busy;
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: random back-pressure, every transfer checked in order
  // ---------------------------------------------------------------------------
  int mon_hold  = 0;
  int mon_quiet = 0;

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      mon_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (projection_q.size() == 0) begin
          $error("projection transfer with no segment outstanding");
          error_count++;
        end else begin
          projection_t e;
          e = projection_q.pop_front();
          check_field("screen_x", e.screen_x, screen_x);
          check_field("screen_y", e.screen_y, screen_y);
          check_field("half_width", e.half_width, half_width);
          check_field("prev_x", e.prev_x, prev_x);
          check_field("prev_y", e.prev_y, prev_y);
          check_field("prev_half_width", e.prev_half_width, prev_half_width);
          check_field("clip_limit", e.clip_limit, clip_limit);
          check_field("visible", e.visible, visible);
          check_field("stripe", e.stripe, stripe);
          checked_count++;
          if (e.visible) visible_count++;
        end
        mon_hold = draw_wait(mon_quiet);
      end else if (mon_hold > 0) begin
        mon_hold--;
      end
      out_stall <= (mon_hold != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_seg(logic f, longint n, longint x, longint y, longint h, longint c);
    segment_t s;
    s.first          = f;
    s.segment_number = 12'(n);
    s.cam_x          = 21'(x);
    s.cam_y          = 17'(y);
    s.seg_height     = 16'(h);
    s.seg_curve      = 10'(c);
    segment_q = {segment_q, s};
  endtask

  // register write, copy updated on the transfer edge
  task automatic write_reg(cfg_reg_t idx, longint value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(value);
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:   scr_w   = value & 64'h1FFF;
      REG_SCREEN_HEIGHT:  scr_h   = value & 64'h1FFF;
      REG_ROAD_WIDTH:     road_w  = value & 64'hFFFF;
      REG_SEGMENT_LENGTH: seg_len = value & 64'hFFF;
      REG_CAMERA_DEPTH:   cam_dep = value & 64'hFFFF;
      default: ;
    endcase
    write_count++;
  endtask

  task automatic write_all(longint w, longint h, longint rw, longint sl, longint cd);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_ROAD_WIDTH, rw);
    write_reg(REG_SEGMENT_LENGTH, sl);
    write_reg(REG_CAMERA_DEPTH, cd);
  endtask

  // every segment sent has come back, block idle; checked mid-cycle once the edge settles
  task automatic drain();
    @(negedge clk);
    while (segment_q.size() != 0 || in_valid || projection_q.size() != 0)
      @(negedge clk);
  endtask

  // extremes now and then, otherwise a typical or a fully random value
  function automatic longint pick(longint lo, longint hi, longint typ_lo, longint typ_hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2, 3: return typ_lo + longint'($urandom_range(0, 32'(typ_hi - typ_lo)));
      default: return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endcase
  endfunction

  // a well-formed frame: fixed camera, rolling hills, curves in runs
  task automatic add_frame(int len);
    longint num, x, y, h, dh, c;
    int     run;
    num = $urandom_range(0, 4095);
    if ($urandom_range(0, 4) == 0) x = longint'(21'sh0 + $signed(21'($urandom)));
    else x = longint'($urandom_range(0, 6000)) - 3000;
    if ($urandom_range(0, 4) == 0) y = longint'(17'sh0 + $signed(17'($urandom)));
    else y = longint'($urandom_range(200, 4000));
    h   = 0;
    dh  = 0;
    c   = 0;
    run = 0;
    for (int i = 0; i < len; i++) begin
      if (run == 0) begin
        run = $urandom_range(1, 10);
        c   = ($urandom_range(0, 2) == 0) ? 0 : longint'($urandom_range(0, 1023)) - 512;
        dh  = longint'($urandom_range(0, 800)) - 400;
      end
      run--;
      h = clamp(h + dh, -32768, 32767);
      push_seg(i == 0, num + i, x, y, h, c);
    end
  endtask

  // fills one phase with frames and stray segments of raw random content
  task automatic add_random(int count);
    int n, len;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
        add_frame(len);
        n += len;
      end else begin
        push_seg($urandom_range(0, 1), $urandom, $signed(21'($urandom)),
                 $signed(17'($urandom)), $signed(16'($urandom)), $signed(10'($urandom)));
        n++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset defaults; first segment without the frame flag runs off the reset state
    push_seg(0, 0, 0, 0, 0, 0);
    push_seg(0, 5, 100, 1500, 0, 0);
    // new frame: zero depth at the nearest segment
    push_seg(1, 3, 0, 1000, 0, 0);
    push_seg(0, 4, 0, 1000, 0, 100);
    // field extremes, pixels pinned at the saturation limits
    push_seg(0, 6, 1048575, -65536, 32767, 511);
    push_seg(0, 7, -1048576, 65535, -32768, -512);
    // crest then dip: a hidden segment behind a visible one
    push_seg(0, 8, 0, 1000, 3000, 0);
    push_seg(0, 9, 0, 1000, -2000, 0);
    push_seg(0, 4095, 0, 1000, 6000, 0);
    // frame restart mid-stream clears the previous-segment fields
    push_seg(1, 0, -500, 1500, 0, -300);
    push_seg(0, 1, -500, 1500, 0, -300);
    push_seg(0, 2, -500, 1500, 0, -300);
    drain();

    // every register at its top, but the screen sizes at 4096
    write_all(4096, 4096, 65535, 4095, 65535);
    push_seg(1, 2, -1048576, -65536, 32767, 511);
    push_seg(0, 3, 1048575, 65535, -32768, -512);
    push_seg(0, 4, 0, 0, 0, 511);
    push_seg(0, 5, 12345, -999, 100, -1);
    drain();

    // every register at one
    write_all(1, 1, 1, 1, 1);
    push_seg(1, 0, 1, 0, 0, 0);
    push_seg(0, 1, 0, -1, 0, 0);
    push_seg(0, 2, -1, 0, 1, 1);
    drain();

    // zero segment length and zero camera depth: every depth is zero
    write_reg(REG_SEGMENT_LENGTH, 0);
    write_reg(REG_CAMERA_DEPTH, 0);
    push_seg(1, 0, 300, 200, 100, 50);
    push_seg(0, 1, 300, 200, 100, 50);
    push_seg(0, 2, 300, 200, 100, 50);
    drain();

    // random phases, each under a fresh register setting
    for (int p = 0; p < 8; p++) begin
      write_all(pick(1, 4096, 320, 1920), pick(1, 4096, 240, 1080),
                pick(1, 65535, 1000, 4000), pick(1, 4095, 100, 300),
                pick(1, 65535, 128, 512));
      add_random(135);
      drain();
    end

    // allow for any stray transfer after the last expected one
    repeat (100) @(posedge clk);

    $display("run covered %0d segments in %0d frames, %0d of them visible",
             checked_count, frame_count, visible_count);
    $display("%0d register writes across extreme, zero-depth and random settings",
             write_count);
    if (error_count == 0 && projection_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #1500000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
design/rsp_pkg.sv
design/rsp_div.sv
design/road_segment_projector.sv
tb/sv/road_segment_projector_tb.sv
